// File: hw/rtl/bounded_ordered_list_engine_defines.svh
// Assertion macros for the bounded ordered list engine.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define BOLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define BOLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bole_pkg.sv
// Types and constants shared by the ordered list engine and its cells.
`timescale 1ns / 1ps
package bole_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned POS_W        = 8;
    localparam int unsigned COUNT_W      = 7;

    typedef enum logic [2:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_BACK  = 3'd1,
        FN_INS_AT    = 3'd2,
        FN_DEL_FRONT = 3'd3,
        FN_DEL_BACK  = 3'd4,
        FN_DEL_AT    = 3'd5,
        FN_DEL_VALUE = 3'd6,
        FN_READ_AT   = 3'd7
    } t_func;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_NO_INDEX = 3'd2,
        ST_NO_VALUE = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        t_func                     func;
        logic signed [POS_W-1:0]   position;
        logic signed [DATA_W-1:0]  item_value;
    } t_cmd;

    typedef struct packed {
        logic                      ok;
        t_status                   status;
        logic signed [DATA_W-1:0]  read_value;
        logic [COUNT_W-1:0]        count;
    } t_result;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic                      cmp_en;
        logic [DATA_W-1:0]         key;
        logic                      ins_en;
        logic [POS_W-1:0]          ins_at;
        logic [DATA_W-1:0]         wr_val;
        logic                      del_en;
        logic                      del_match;
        logic [POS_W-1:0]          del_at;
    } t_cell_ctl;

endpackage

// File: hw/rtl/bole_cell.sv
// One list slot: holds a value, shifts toward either neighbor, compares against a key.
`timescale 1ns / 1ps
module bole_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                          i_clk,
    input  bole_pkg::t_cell_ctl           i_ctl,
    input  logic                          i_hit_upto,
    input  logic [bole_pkg::DATA_W-1:0]   i_left,
    input  logic [bole_pkg::DATA_W-1:0]   i_right,
    output logic [bole_pkg::DATA_W-1:0]   o_value,
    output logic                          o_match
);
    import bole_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;
    logic              r_match;
    logic              n_match;

    always_comb begin
        n_value = r_value;
        n_match = r_match;
        if (i_ctl.cmp_en) begin
            n_match = (r_value == i_ctl.key);
        end
        if (i_ctl.ins_en) begin
            if (MY_IDX == i_ctl.ins_at) begin
                n_value = i_ctl.wr_val;
            end else if (MY_IDX > i_ctl.ins_at) begin
                n_value = i_left;
            end
        end
        if (i_ctl.del_en) begin
            // by value: every slot from the first hit upward closes the gap
            if (i_ctl.del_match ? i_hit_upto : (MY_IDX >= i_ctl.del_at)) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_match <= n_match;
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

// File: hw/rtl/bounded_ordered_list_engine.sv
// Top level: command sequencer, count register and the row of list cells.
// The result strobe o_done is registered from busy, which is registered from the accept.
// No new command is accepted while busy is high; busy stays high for one cycle while the
//   per-cell compare registers feed the shift and select logic.
// o_done lasts one cycle; o_result holds until the next result; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) empties the list; cell contents are left as they are.
`timescale 1ns / 1ps
`include "bounded_ordered_list_engine_defines.svh"
module bounded_ordered_list_engine #(
    parameter int unsigned CAPACITY = bole_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  bole_pkg::t_cmd     i_cmd,
    output logic               busy,
    output logic               o_done,
    output bole_pkg::t_result  o_result
);
    import bole_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic                      r_busy;
    t_func                     r_func;
    logic [POS_W-1:0]          r_pos;
    logic [DATA_W-1:0]         r_val;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic                      r_done;
    t_result                   r_res;
    t_result                   n_res;

    t_cell_ctl                 cell_ctl;
    logic [DATA_W-1:0]         cell_val [CAPACITY];
    logic [CAPACITY-1:0]       cell_match;
    logic [CAPACITY-1:0]       hit_valid;
    logic [CAPACITY-1:0]       hit_upto;
    logic [DATA_W-1:0]         rd_sel;

    logic                      accept;
    logic                      pos_neg;
    logic [POS_W-1:0]          pmag;
    logic [POS_W-1:0]          cnt8;
    logic                      idx_bad;
    logic                      is_full;
    logic                      is_empty;
    logic                      is_ins;

    assign accept   = start && !r_busy;
    assign pos_neg  = r_pos[POS_W-1];
    assign pmag     = {1'b0, r_pos[POS_W-2:0]};
    assign cnt8     = POS_W'(r_count);
    assign idx_bad  = pos_neg || (pmag >= cnt8);
    assign is_full  = (r_count >= CW'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign is_ins   = (r_func == FN_INS_FRONT) || (r_func == FN_INS_BACK) ||
                      (r_func == FN_INS_AT);

    // Cell row
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DATA_W-1:0] left_v;
            logic [DATA_W-1:0] right_v;
            if (gi == 0) begin : g_first
                assign left_v = cell_ctl.wr_val;
            end else begin : g_mid_l
                assign left_v = cell_val[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_v = cell_val[gi];
            end else begin : g_mid_r
                assign right_v = cell_val[gi+1];
            end

            assign hit_valid[gi] = cell_match[gi] && (CW'(gi) < r_count);
            assign hit_upto[gi]  = |hit_valid[gi:0];

            bole_cell #(
                .IDX (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (cell_ctl),
                .i_hit_upto (hit_upto[gi]),
                .i_left     (left_v),
                .i_right    (right_v),
                .o_value    (cell_val[gi]),
                .o_match    (cell_match[gi])
            );
        end
    endgenerate

    // AND-OR select for read at position
    always_comb begin
        rd_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_sel = rd_sel | (cell_val[i] & {DATA_W{pmag == POS_W'(i)}});
        end
    end

    always_comb begin
        cell_ctl           = '0;
        cell_ctl.cmp_en    = accept;
        cell_ctl.key       = i_cmd.item_value;
        cell_ctl.wr_val    = r_val;
        n_count            = r_count;
        n_res              = '0;
        n_res.status       = ST_DONE;

        if (r_busy) begin
            if (is_ins) begin
                if (is_full) begin
                    n_res.status = ST_FULL;
                end else begin
                    cell_ctl.ins_en = 1'b1;
                    unique case (r_func)
                        FN_INS_FRONT: cell_ctl.ins_at = '0;
                        FN_INS_BACK:  cell_ctl.ins_at = cnt8;
                        default: begin
                            if (pos_neg || pmag == '0 || is_empty) begin
                                cell_ctl.ins_at = '0;
                            end else begin
                                cell_ctl.ins_at = (pmag < cnt8) ? pmag : cnt8;
                            end
                        end
                    endcase
                    n_count  = r_count + CW'(1);
                    n_res.ok = 1'b1;
                end
            end else if (is_empty) begin
                n_res.status = ST_EMPTY;
            end else begin
                unique case (r_func)
                    FN_DEL_FRONT: begin
                        cell_ctl.del_en = 1'b1;
                        n_count         = r_count - CW'(1);
                        n_res.ok        = 1'b1;
                    end
                    FN_DEL_BACK: begin
                        cell_ctl.del_en = 1'b1;
                        cell_ctl.del_at = cnt8 - POS_W'(1);
                        n_count         = r_count - CW'(1);
                        n_res.ok        = 1'b1;
                    end
                    FN_DEL_AT: begin
                        if (idx_bad) begin
                            n_res.status = ST_NO_INDEX;
                        end else begin
                            cell_ctl.del_en = 1'b1;
                            cell_ctl.del_at = pmag;
                            n_count         = r_count - CW'(1);
                            n_res.ok        = 1'b1;
                        end
                    end
                    FN_DEL_VALUE: begin
                        if (|hit_valid) begin
                            cell_ctl.del_en    = 1'b1;
                            cell_ctl.del_match = 1'b1;
                            n_count            = r_count - CW'(1);
                            n_res.ok           = 1'b1;
                        end else begin
                            n_res.status = ST_NO_VALUE;
                        end
                    end
                    FN_READ_AT: begin
                        if (idx_bad) begin
                            n_res.status = ST_NO_INDEX;
                        end else begin
                            n_res.ok         = 1'b1;
                            n_res.read_value = rd_sel;
                        end
                    end
                    default: ;
                endcase
            end
            n_res.count = COUNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_busy  <= accept;
            r_count <= n_count;
            r_done  <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_cmd.func;
            r_pos  <= i_cmd.position;
            r_val  <= i_cmd.item_value;
        end
        if (r_busy) begin
            r_res <= n_res;
        end
    end

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_result = r_res;

    `BOLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `BOLE_ASSERT_NEXT(a_busy_done, busy, o_done && !busy, "busy cycle not followed by a result")
    `BOLE_ASSERT_NOW(a_ok_status, o_done, o_result.ok == (o_result.status == ST_DONE), "ok and status disagree")
    `BOLE_ASSERT_NOW(a_count_cap, 1'b1, r_count <= CW'(CAPACITY), "element count above capacity")
    `BOLE_ASSERT_NEXT(a_count_step, !busy, r_count == $past(r_count), "count moved outside a busy cycle")

endmodule
